/* hdl/lsw_pkg.sv */
// ----------------------------------------------------------------------------
// lsw_pkg: shared types and constants of the segment window clipper
// Register indexes, reset values and the per-edge flag word.
// ----------------------------------------------------------------------------
`default_nettype none

package lsw_pkg;

  // Number of window edges tested per segment
  localparam int NUM_EDGES = 4;

  // Configuration port index width
  localparam int CFG_IDX_W = 2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 2'd0,
    CFG_RIGHT  = 2'd1,
    CFG_BOTTOM = 2'd2,
    CFG_TOP    = 2'd3
  } cfg_idx_e;

  // Window reset values
  localparam int WIN_LEFT_RST   = 50;
  localparam int WIN_RIGHT_RST  = 300;
  localparam int WIN_BOTTOM_RST = 250;
  localparam int WIN_TOP_RST    = 500;

  // Per-edge status worked out before the divide
  typedef struct packed {
    logic s_neg;   // denominator below zero
    logic s_zero;  // denominator zero, edge parallel
    logic u_neg;   // distance below zero
    logic q_neg;   // ratio takes a minus sign
    logic clamp;   // ratio saturates at two
  } edge_flag_t;

  localparam int FLAG_W = $bits(edge_flag_t);

endpackage

`default_nettype wire

/* hdl/lsw_if.sv */
// ----------------------------------------------------------------------------
// lsw_if: segment and result channels
// Valid/ready channels carrying one segment word or one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsw_seg_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsw_res_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic                 visible;
  logic signed [CW-1:0] clip_start_x;
  logic signed [CW-1:0] clip_start_y;
  logic signed [CW-1:0] clip_end_x;
  logic signed [CW-1:0] clip_end_y;

  modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, input ready);
  modport sink   (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, output ready);
endinterface

`default_nettype wire

/* hdl/lsw_div_cell.sv */
// ----------------------------------------------------------------------------
// lsw_div_cell: one restoring divide step for the left, right, bottom and top sides
// Produces one quotient bit per edge and hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lsw_div_cell
  import lsw_pkg::*;
#(
  parameter int RW = 18,
  parameter int QW = 17,
  parameter int SW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [RW-1:0] rem_i [NUM_EDGES],
  input  wire logic [RW-1:0] dvs_i [NUM_EDGES],
  input  wire logic [QW-1:0] quo_i [NUM_EDGES],
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output logic [RW-1:0]      rem_o [NUM_EDGES],
  output logic [RW-1:0]      dvs_o [NUM_EDGES],
  output logic [QW-1:0]      quo_o [NUM_EDGES],
  output logic [SW-1:0]      side_o
);

  logic          valid_q;
  logic          load;
  logic [RW-1:0] rem_d [NUM_EDGES];
  logic          bit_d [NUM_EDGES];

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_o = valid_q;

  // Compare, subtract and shift each partial remainder
  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      bit_d[e] = (rem_i[e] >= dvs_i[e]);
      rem_d[e] = bit_d[e] ? (rem_i[e] - dvs_i[e]) : rem_i[e];
      rem_d[e] = {rem_d[e][RW-2:0], 1'b0};
    end
  end

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the word while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int e = 0; e < NUM_EDGES; e++) begin
        rem_o[e] <= rem_d[e];
        dvs_o[e] <= dvs_i[e];
        quo_o[e] <= {quo_i[e][QW-2:0], bit_d[e]};
      end
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/lsw_edge_unit.sv */
// ----------------------------------------------------------------------------
// lsw_edge_unit: parametric limit update over the left, right, bottom and top sides
// Turns the quotients into signed ratios and tightens or rejects in order.
// ----------------------------------------------------------------------------
`default_nettype none

module lsw_edge_unit
  import lsw_pkg::*;
#(
  parameter int FB = 16
) (
  input  wire logic [FB:0]   quo_i  [NUM_EDGES],
  input  wire edge_flag_t    flag_i [NUM_EDGES],
  output logic               ok_o,
  output logic [FB:0]        te_o,
  output logic [FB:0]        tx_o
);

  localparam int TW = FB + 3;
  localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< FB;
  localparam logic signed [TW-1:0] T_TWO = TW'(2) <<< FB;

  // Walk left, right, bottom, top in order
  always_comb begin
    logic signed [TW-1:0] te;
    logic signed [TW-1:0] tx;
    logic signed [TW-1:0] r;
    logic                 ok;
    te = '0;
    tx = T_ONE;
    ok = 1'b1;
    for (int e = 0; e < NUM_EDGES; e++) begin
      r = flag_i[e].clamp ? T_TWO : signed'(TW'(quo_i[e]));
      if (flag_i[e].q_neg) begin
        r = -r;
      end
      if (ok) begin
        if (flag_i[e].s_neg) begin
          if (r > tx) begin
            ok = 1'b0;
          end else if (r > te) begin
            te = r;
          end
        end else if (!flag_i[e].s_zero) begin
          if (r < te) begin
            ok = 1'b0;
          end else if (r < tx) begin
            tx = r;
          end
        end else if (flag_i[e].u_neg) begin
          ok = 1'b0;
        end
      end
    end
    ok_o = ok;
    te_o = te[FB:0];
    tx_o = tx[FB:0];
  end

endmodule

`default_nettype wire

/* hdl/line_segment_window_clip_core.sv */
// ----------------------------------------------------------------------------
// line_segment_window_clip_core: segment clipper against a window
// Liang-Barsky clip in a divide-cell row; a segment per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  ---------+-----+-----------------------------------------------------
//  in_s     | in  | start_x, start_y, end_x, end_y
//  out_s    | out | visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i (window registers)
//
//  One segment per cycle unless out_s stalls. Stages: one setup stage,
//  FRAC_BITS+1 divide cells (one quotient bit each), the edge stage, the
//  multiply stage and the output register.
//  Every stage holds its own valid bit, so bubbles close up under stalls.
//  Reset clears the valid bits and loads the window reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_window_clip_core
  import lsw_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [COORD_BITS-1:0] cfg_data_i,
  lsw_seg_if.sink                    in_s,
  lsw_res_if.source                  out_s
);

  localparam int CB    = COORD_BITS;
  localparam int FB    = FRAC_BITS;
  localparam int EW    = CB + 2;
  localparam int RW    = EW;
  localparam int QW    = FB + 1;
  localparam int STEPS = FB + 1;
  localparam int SW    = 4 * CB + 2 + NUM_EDGES * FLAG_W;
  localparam int PW    = FB + 1 + CB;

  // Window registers
  logic signed [CB-1:0] win_left_q, win_right_q, win_bottom_q, win_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= CB'(WIN_LEFT_RST);
      win_right_q  <= CB'(WIN_RIGHT_RST);
      win_bottom_q <= CB'(WIN_BOTTOM_RST);
      win_top_q    <= CB'(WIN_TOP_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFT:   win_left_q   <= cfg_data_i;
        CFG_RIGHT:  win_right_q  <= cfg_data_i;
        CFG_BOTTOM: win_bottom_q <= cfg_data_i;
        CFG_TOP:    win_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Setup stage: deltas, distances, magnitudes and flags
  logic signed [EW-1:0] x1, y1, dx, dy;
  logic signed [EW-1:0] s_v [NUM_EDGES];
  logic signed [EW-1:0] u_v [NUM_EDGES];
  logic [RW-1:0]        as_v [NUM_EDGES];
  logic [RW-1:0]        au_v [NUM_EDGES];
  edge_flag_t           flg_v [NUM_EDGES];
  logic [CB-1:0]        mdx, mdy;
  logic [SW-1:0]        side_d;

  always_comb begin
    x1 = EW'(in_s.start_x);
    y1 = EW'(in_s.start_y);
    dx = EW'(in_s.end_x) - x1;
    dy = EW'(in_s.end_y) - y1;
    s_v[0] = -dx;  u_v[0] = x1 - EW'(win_left_q);
    s_v[1] = dx;   u_v[1] = EW'(win_right_q) - x1;
    s_v[2] = -dy;  u_v[2] = y1 - EW'(win_bottom_q);
    s_v[3] = dy;   u_v[3] = EW'(win_top_q) - y1;
    for (int e = 0; e < NUM_EDGES; e++) begin
      as_v[e] = (s_v[e] < 0) ? RW'(-s_v[e]) : RW'(s_v[e]);
      au_v[e] = (u_v[e] < 0) ? RW'(-u_v[e]) : RW'(u_v[e]);
      flg_v[e].s_neg  = (s_v[e] < 0);
      flg_v[e].s_zero = (s_v[e] == 0);
      flg_v[e].u_neg  = (u_v[e] < 0);
      flg_v[e].q_neg  = (u_v[e] < 0) != (s_v[e] < 0);
      flg_v[e].clamp  = ({1'b0, au_v[e]} >= {as_v[e], 1'b0});
    end
    mdx = (dx < 0) ? CB'(-dx) : CB'(dx);
    mdy = (dy < 0) ? CB'(-dy) : CB'(dy);
    side_d = {in_s.start_x, in_s.start_y, dx < 0, mdx, dy < 0, mdy,
              flg_v[0], flg_v[1], flg_v[2], flg_v[3]};
  end

  // Cell boundary signals
  logic          c_valid [STEPS+1];
  logic          c_ready [STEPS+1];
  logic [RW-1:0] c_rem   [STEPS+1][NUM_EDGES];
  logic [RW-1:0] c_dvs   [STEPS+1][NUM_EDGES];
  logic [QW-1:0] c_quo   [STEPS+1][NUM_EDGES];
  logic [SW-1:0] c_side  [STEPS+1];

  logic fv_q;
  logic f_rdy;

  assign f_rdy      = !fv_q || c_ready[0];
  assign in_s.ready = f_rdy;
  assign c_valid[0] = fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (f_rdy) begin
      fv_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && f_rdy) begin
      for (int e = 0; e < NUM_EDGES; e++) begin
        c_rem[0][e] <= au_v[e];
        c_dvs[0][e] <= as_v[e];
        c_quo[0][e] <= '0;
      end
      c_side[0] <= side_d;
    end
  end

  // Row of divide cells
  for (genvar k = 0; k < STEPS; k++) begin : g_div
    lsw_div_cell #(.RW(RW), .QW(QW), .SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[k]),
      .ready_o (c_ready[k]),
      .rem_i   (c_rem[k]),
      .dvs_i   (c_dvs[k]),
      .quo_i   (c_quo[k]),
      .side_i  (c_side[k]),
      .valid_o (c_valid[k+1]),
      .ready_i (c_ready[k+1]),
      .rem_o   (c_rem[k+1]),
      .dvs_o   (c_dvs[k+1]),
      .quo_o   (c_quo[k+1]),
      .side_o  (c_side[k+1])
    );
  end

  // Edge stage
  edge_flag_t           e_flag [NUM_EDGES];
  logic                 e_ok;
  logic [FB:0]          e_te, e_tx;
  logic signed [CB-1:0] e_x1, e_y1;
  logic                 e_dxn, e_dyn;
  logic [CB-1:0]        e_mdx, e_mdy;

  assign {e_x1, e_y1, e_dxn, e_mdx, e_dyn, e_mdy,
          e_flag[0], e_flag[1], e_flag[2], e_flag[3]} = c_side[STEPS];

  lsw_edge_unit #(.FB(FB)) u_edge (
    .quo_i  (c_quo[STEPS]),
    .flag_i (e_flag),
    .ok_o   (e_ok),
    .te_o   (e_te),
    .tx_o   (e_tx)
  );

  logic                 ev_q, e_rdy;
  logic                 eok_q, edxn_q, edyn_q;
  logic [FB:0]          ete_q, etx_q;
  logic signed [CB-1:0] ex1_q, ey1_q;
  logic [CB-1:0]        emdx_q, emdy_q;

  logic mv_q, m_rdy, ov_q, o_rdy;

  assign o_rdy = !ov_q || out_s.ready;
  assign m_rdy = !mv_q || o_rdy;
  assign e_rdy = !ev_q || m_rdy;
  assign c_ready[STEPS] = e_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
    end else if (e_rdy) begin
      ev_q <= c_valid[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid[STEPS] && e_rdy) begin
      eok_q  <= e_ok;
      ete_q  <= e_te;
      etx_q  <= e_tx;
      ex1_q  <= e_x1;
      ey1_q  <= e_y1;
      edxn_q <= e_dxn;
      edyn_q <= e_dyn;
      emdx_q <= e_mdx;
      emdy_q <= e_mdy;
    end
  end

  // Multiply stage: t times delta magnitude
  logic [PW-1:0]        p_q [4];
  logic                 mok_q, mdxn_q, mdyn_q;
  logic signed [CB-1:0] mx1_q, my1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (m_rdy) begin
      mv_q <= ev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_q && m_rdy) begin
      p_q[0] <= PW'(ete_q) * PW'(emdx_q);
      p_q[1] <= PW'(ete_q) * PW'(emdy_q);
      p_q[2] <= PW'(etx_q) * PW'(emdx_q);
      p_q[3] <= PW'(etx_q) * PW'(emdy_q);
      mok_q  <= eok_q;
      mdxn_q <= edxn_q;
      mdyn_q <= edyn_q;
      mx1_q  <= ex1_q;
      my1_q  <= ey1_q;
    end
  end

  // Output stage: offset from start point, truncate toward zero
  logic signed [CB-1:0] pt_d [4];

  always_comb begin
    logic signed [EW-1:0] base;
    logic signed [EW-1:0] res;
    logic [CB:0]          whole;
    logic                 sticky;
    logic                 neg;
    for (int i = 0; i < 4; i++) begin
      base   = (i % 2 == 0) ? EW'(mx1_q) : EW'(my1_q);
      neg    = (i % 2 == 0) ? mdxn_q : mdyn_q;
      whole  = p_q[i][PW-1:FB];
      sticky = |p_q[i][FB-1:0];
      if (!neg) begin
        res = base + EW'(whole);
        if (sticky && res < 0) begin
          res = res + EW'(1);
        end
      end else begin
        res = base - EW'(whole);
        if (sticky && res > 0) begin
          res = res - EW'(1);
        end
      end
      pt_d[i] = mok_q ? res[CB-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (o_rdy) begin
      ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv_q && o_rdy) begin
      out_s.visible      <= mok_q;
      out_s.clip_start_x <= pt_d[0];
      out_s.clip_start_y <= pt_d[1];
      out_s.clip_end_x   <= pt_d[2];
      out_s.clip_end_y   <= pt_d[3];
    end
  end

  assign out_s.valid = ov_q;

endmodule

`default_nettype wire

/* hdl/lsw_checker.sv */
// ----------------------------------------------------------------------------
// lsw_checker: port-level checks of the segment window clipper
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsw_checker #(
  parameter int CW = 16
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic          visible,
  input wire logic [CW-1:0] sx,
  input wire logic [CW-1:0] sy,
  input wire logic [CW-1:0] ex,
  input wire logic [CW-1:0] ey
);

  // No result word right after reset releases
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid)
    else $error("result word present out of reset");

  // Rejected segment carries zero coordinates
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !visible |-> (sx == '0) && (sy == '0) && (ex == '0) && (ey == '0))
    else $error("rejected word with nonzero coordinates");

  // Hold a stalled result word
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable({visible, sx, sy, ex, ey}))
    else $error("result word changed while stalled");

endmodule

bind line_segment_window_clip_core lsw_checker #(.CW(COORD_BITS)) u_lsw_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .visible   (out_s.visible),
  .sx        (out_s.clip_start_x),
  .sy        (out_s.clip_start_y),
  .ex        (out_s.clip_end_x),
  .ey        (out_s.clip_end_y)
);

`default_nettype wire
